// File: design/rmdd_pkg.sv
// Package for the running maximum drawdown block.
// Holds field widths, scaling constants and the sequencer state type.
// No dependencies.
package rmdd_pkg;

    // Default price width in bits, two's complement
    localparam int PRICE_WIDTH_DEF = 32;

    // Fixed port widths
    localparam int PRICE_PORT_W = 32;
    localparam int DD_W         = 16;

    // Basis point scale and its width
    localparam int SCALE_W = 14;
    localparam logic [SCALE_W-1:0] BP_SCALE = SCALE_W'(10000);

    // Saturation value of the drawdown
    localparam logic [DD_W-1:0] DD_MAX = '1;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCALE,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

endpackage

// File: design/running_max_drawdown.sv
// Accept to out_valid passes through the scale, divide and finish states, or straight to
// finish for a non-positive peak. A new sample is taken only back in idle, after the result
// is presented; the shared restoring divider makes one quotient bit per cycle over
// PRICE_WIDTH+15 bits. A stalled output holds the result and delays the next accept.
// Reset (rst_n, asynchronous, active low) clears the sequencer, the series state
// and the output valid; no clearing pass is needed.
// Running maximum drawdown in basis points; one multiplier and a serial divider.
// Depends on rmdd_pkg.
module running_max_drawdown #(
    parameter int PRICE_WIDTH = rmdd_pkg::PRICE_WIDTH_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // input channel
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [rmdd_pkg::PRICE_PORT_W-1:0] price_sample,
    input  logic                                   last_sample,
    // output channel
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [rmdd_pkg::DD_W-1:0]              max_drawdown_bp,
    output logic                                   drawdown_saturated,
    output logic signed [rmdd_pkg::PRICE_PORT_W-1:0] running_peak,
    output logic                                   series_end
);
    import rmdd_pkg::*;

    // Derived widths
    localparam int DIFF_W = PRICE_WIDTH + 1;          // peak minus sample, never negative
    localparam int DIV_W  = DIFF_W + SCALE_W;         // scaled dividend / quotient
    localparam int REM_W  = PRICE_WIDTH + 1;          // partial remainder
    localparam int CNT_W  = $clog2(DIV_W);

    // Sequencer and datapath registers
    state_t                  state_reg, state_next;
    logic signed [PRICE_WIDTH-1:0] peak_reg, peak_next;
    logic [DIFF_W-1:0]       diff_reg, diff_next;
    logic [DIV_W-1:0]        quot_reg, quot_next;
    logic [REM_W-1:0]        rem_reg, rem_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    last_reg, last_next;
    logic [DD_W-1:0]         worst_reg, worst_next;
    logic                    ovf_reg, ovf_next;
    logic                    open_reg, open_next;

    // Output registers
    logic                    out_valid_reg, out_valid_next;
    logic [DD_W-1:0]         out_dd_reg, out_dd_next;
    logic                    out_sat_reg, out_sat_next;
    logic [PRICE_PORT_W-1:0] out_peak_reg, out_peak_next;
    logic                    out_end_reg, out_end_next;

    // Combinational helpers
    logic signed [PRICE_WIDTH-1:0] sample_v;
    logic [PRICE_PORT_W-1:0] peak_port;
    logic [REM_W-1:0]        rem_shift;
    logic [REM_W:0]          trial;
    logic                    borrow;
    logic                    quot_over;
    logic [DD_W-1:0]         dd_val;
    logic                    peak_pos;
    logic                    out_free;

    // Sample at the internal price width
    generate
        if (PRICE_WIDTH <= PRICE_PORT_W) begin : g_in_narrow
            assign sample_v = price_sample[PRICE_WIDTH-1:0];
        end
        else begin : g_in_wide
            assign sample_v = {{(PRICE_WIDTH-PRICE_PORT_W){price_sample[PRICE_PORT_W-1]}},
                               price_sample};
        end
    endgenerate

    // Peak as reported on the port, masked to the price width
    generate
        if (PRICE_WIDTH >= PRICE_PORT_W) begin : g_out_wide
            assign peak_port = peak_reg[PRICE_PORT_W-1:0];
        end
        else begin : g_out_narrow
            assign peak_port = {{(PRICE_PORT_W-PRICE_WIDTH){1'b0}}, peak_reg};
        end
    endgenerate

    // Shared restoring divide step: one quotient bit per cycle
    assign rem_shift = {rem_reg[REM_W-2:0], quot_reg[DIV_W-1]};
    assign trial     = {1'b0, rem_shift} - {2'b00, peak_reg};
    assign borrow    = trial[REM_W];

    // Quotient saturation
    assign quot_over = |quot_reg[DIV_W-1:DD_W];
    assign dd_val    = quot_over ? DD_MAX : quot_reg[DD_W-1:0];

    assign peak_pos  = !peak_reg[PRICE_WIDTH-1] && (peak_reg != '0);
    assign out_free  = !out_valid_reg || !out_stall;

    // State and data registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            peak_reg      <= '0;
            worst_reg     <= '0;
            ovf_reg       <= 1'b0;
            open_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            peak_reg      <= peak_next;
            worst_reg     <= worst_next;
            ovf_reg       <= ovf_next;
            open_reg      <= open_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        diff_reg     <= diff_next;
        quot_reg     <= quot_next;
        rem_reg      <= rem_next;
        cnt_reg      <= cnt_next;
        last_reg     <= last_next;
        out_dd_reg   <= out_dd_next;
        out_sat_reg  <= out_sat_next;
        out_peak_reg <= out_peak_next;
        out_end_reg  <= out_end_next;
    end

    // Sequencer: next state and datapath control
    always_comb
    begin
        state_next     = state_reg;
        peak_next      = peak_reg;
        diff_next      = diff_reg;
        quot_next      = quot_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        last_next      = last_reg;
        worst_next     = worst_reg;
        ovf_next       = ovf_reg;
        open_next      = open_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_dd_next    = out_dd_reg;
        out_sat_next   = out_sat_reg;
        out_peak_next  = out_peak_reg;
        out_end_next   = out_end_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    last_next = last_sample;
                    open_next = 1'b1;
                    // first sample of a series loads the peak and clears the series state
                    if (!open_reg)
                    begin
                        peak_next  = sample_v;
                        worst_next = '0;
                        ovf_next   = 1'b0;
                    end
                    else if (sample_v > peak_reg)
                    begin
                        peak_next = sample_v;
                    end
                    diff_next = {peak_next[PRICE_WIDTH-1], peak_next}
                              - {sample_v[PRICE_WIDTH-1], sample_v};
                    if (!peak_next[PRICE_WIDTH-1] && (peak_next != '0))
                        state_next = ST_SCALE;
                    else
                        state_next = ST_FINISH;
                end
            end

            ST_SCALE:
            begin
                // scale the difference to basis points
                quot_next  = DIV_W'(diff_reg) * DIV_W'(BP_SCALE);
                rem_next   = '0;
                cnt_next   = CNT_W'(DIV_W - 1);
                state_next = ST_DIVIDE;
            end

            ST_DIVIDE:
            begin
                if (!borrow)
                    rem_next = trial[REM_W-1:0];
                else
                    rem_next = rem_shift;
                quot_next = {quot_reg[DIV_W-2:0], !borrow};
                if (cnt_reg == '0)
                    state_next = ST_FINISH;
                else
                    cnt_next = cnt_reg - 1'b1;
            end

            ST_FINISH:
            begin
                if (out_free)
                begin
                    // fold this drawdown into the series maximum
                    if (peak_pos)
                    begin
                        if (quot_over)
                            ovf_next = 1'b1;
                        if (dd_val > worst_reg)
                            worst_next = dd_val;
                    end
                    out_valid_next = 1'b1;
                    out_dd_next    = worst_next;
                    out_sat_next   = ovf_next;
                    out_peak_next  = peak_port;
                    out_end_next   = last_reg;
                    if (last_reg)
                        open_next = 1'b0;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Ports
    assign in_stall           = (state_reg != ST_IDLE);
    assign out_valid          = out_valid_reg;
    assign max_drawdown_bp    = out_dd_reg;
    assign drawdown_saturated = out_sat_reg;
    assign running_peak       = out_peak_reg;
    assign series_end         = out_end_reg;

    // Saturation flag implies the kept maximum sits at full scale
    a_sat_full: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> (worst_reg == DD_MAX))
        else $error("saturation flag set without full-scale drawdown");

    // Partial remainder stays below the divisor
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIVIDE) |-> (rem_reg < {1'b0, peak_reg}))
        else $error("divider remainder out of range");

    // Only a positive peak enters the divider
    a_div_peak: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCALE || state_reg == ST_DIVIDE) |-> peak_pos)
        else $error("divider started with non-positive peak");

    // Accepted transaction moves the sequencer out of idle
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == ST_SCALE || state_reg == ST_FINISH))
        else $error("accepted transaction did not start work");

    // Finishing with a free output slot presents a result and returns to idle
    a_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && out_free) |=> (out_valid && state_reg == ST_IDLE))
        else $error("result not presented at finish");

endmodule

// File: tb/tb_running_max_drawdown.sv
// Self-checking testbench for running_max_drawdown: directed and random price series.
// A local drawdown predictor checks every result; both channels idle and stall at random.
// Depends on rmdd_pkg and running_max_drawdown.
module tb_running_max_drawdown;
    import rmdd_pkg::*;

    localparam int CLK_PERIOD     = 8;
    localparam int RESET_CYCLES   = 6;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 100;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int RANDOM_ITEMS   = 1810;
    localparam int QUIET_ITEMS    = 200;

    // One expected result transaction
    typedef struct packed {
        logic [DD_W-1:0]                dd_bp;
        logic                           saturated;
        logic signed [PRICE_PORT_W-1:0] peak;
        logic                           ends_series;
    } drawdown_result_t;

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic signed [PRICE_PORT_W-1:0] price_sample;
    logic last_sample;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [DD_W-1:0] max_drawdown_bp;
    logic drawdown_saturated;
    logic signed [PRICE_PORT_W-1:0] running_peak;
    logic series_end;

    // Predictor state
    logic signed [63:0] peak_q;
    logic [DD_W-1:0]    worst_bp;
    logic               sat_seen;
    logic               series_live;

    drawdown_result_t pending_drawdowns[$];
    int unsigned fail_count = 0;
    int unsigned sent_count = 0;
    int unsigned idle_cycles = 0;
    int unsigned rx_hold_left = 0;
    int unsigned rx_burst_left = 0;
    bit src_idle_en = 1'b1;
    bit rx_idle_en = 1'b1;

    running_max_drawdown dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .price_sample       (price_sample),
        .last_sample        (last_sample),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .max_drawdown_bp    (max_drawdown_bp),
        .drawdown_saturated (drawdown_saturated),
        .running_peak       (running_peak),
        .series_end         (series_end)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Predict the result of one sample and queue it
    function automatic void predict_drawdown(logic signed [PRICE_PORT_W-1:0] price,
                                             logic is_last);
        logic signed [63:0] v;
        logic [63:0]        diff;
        logic [63:0]        bp;
        drawdown_result_t   r;
        v = 64'(price);
        if (!series_live)
        begin
            peak_q      = v;
            worst_bp    = '0;
            sat_seen    = 1'b0;
            series_live = 1'b1;
        end
        else if (v > peak_q)
        begin
            peak_q = v;
        end
        // drawdown only against a positive peak
        if (peak_q > 0)
        begin
            diff = $unsigned(peak_q - v);
            bp   = (diff * 64'(BP_SCALE)) / $unsigned(peak_q);
            if (bp > 64'(DD_MAX))
            begin
                bp       = 64'(DD_MAX);
                sat_seen = 1'b1;
            end
            if (bp > 64'(worst_bp))
                worst_bp = bp[DD_W-1:0];
        end
        r.dd_bp       = worst_bp;
        r.saturated   = sat_seen;
        r.peak        = peak_q[PRICE_PORT_W-1:0];
        r.ends_series = is_last;
        pending_drawdowns.push_back(r);
        if (is_last)
            series_live = 1'b0;
    endfunction

    // Offer one sample until accepted; valid stays high unless a gap is taken
    task automatic send_sample(logic signed [PRICE_PORT_W-1:0] price, logic is_last);
        int unsigned gap;
        if (src_idle_en && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 15);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        price_sample <= price;
        last_sample  <= is_last;
        in_valid     <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict_drawdown(price, is_last);
        sent_count++;
    endtask

    // Sender pause until every expected result has come back
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_drawdowns.size() != 0) @(posedge clk);
    endtask

    task automatic test_single_sample_series();
        send_sample(32'sd1000, 1'b1);
        send_sample(-32'sd7, 1'b1);
        send_sample(32'sd0, 1'b1);
        send_sample(32'sh7fff_ffff, 1'b1);
        send_sample(32'sh8000_0000, 1'b1);
    endtask

    task automatic test_nonpositive_peak();
        // peak stays at or below zero, then turns positive
        send_sample(-32'sd500, 1'b0);
        send_sample(-32'sd900, 1'b0);
        send_sample(-32'sd100, 1'b0);
        send_sample(32'sd0, 1'b0);
        send_sample(32'sd50, 1'b0);
        send_sample(32'sd25, 1'b1);
        // a positive peak falling to zero is a full drawdown
        send_sample(32'sd1, 1'b0);
        send_sample(32'sd0, 1'b1);
    endtask

    task automatic test_saturation();
        send_sample(32'sd1, 1'b0);
        send_sample(-32'sd10, 1'b0);
        // flag and maximum hold for the rest of the series
        send_sample(32'sh7fff_ffff, 1'b0);
        send_sample(32'sh8000_0000, 1'b1);
        // a new series clears both
        send_sample(32'sd10, 1'b0);
        send_sample(32'sd9, 1'b1);
    endtask

    task automatic test_extreme_prices();
        send_sample(32'sh7fff_ffff, 1'b0);
        send_sample(32'sh8000_0000, 1'b0);
        send_sample(32'sh7fff_fffe, 1'b1);
        send_sample(32'sd100, 1'b0);
        send_sample(32'sh8000_0000, 1'b1);
        wait_for_drain();
    endtask

    // Receiver holds off for a long stretch while samples keep coming
    task automatic test_output_backpressure();
        src_idle_en  = 1'b0;
        rx_hold_left = RX_HOLD_CYCLES;
        for (int i = 0; i < 16; i++)
            send_sample($urandom_range(1, 32'h7fff_ffff), (i % 5) == 4);
        wait_for_drain();
        src_idle_en = 1'b1;
    endtask

    // Random series: mostly price walks, plus raw, small, extreme and crashing values
    task automatic test_random_series();
        int unsigned stop_at;
        int unsigned len;
        int unsigned mode;
        int          d;
        longint      cur;
        logic signed [PRICE_PORT_W-1:0] price;
        stop_at = sent_count + RANDOM_ITEMS;
        while (sent_count < stop_at)
        begin
            // new idling pattern per chunk; none near the end
            if (sent_count % 150 == 0)
            begin
                src_idle_en = $urandom_range(0, 3) != 0;
                rx_idle_en  = $urandom_range(0, 3) != 0;
                if ($urandom_range(0, 2) == 0)
                    wait_for_drain();
            end
            if (sent_count + QUIET_ITEMS >= stop_at)
            begin
                src_idle_en = 1'b0;
                rx_idle_en  = 1'b0;
            end
            len  = $urandom_range(1, 12);
            mode = $urandom_range(0, 9);
            cur  = longint'($urandom_range(1, 32'h7fff_ffff)) >> $urandom_range(0, 30);
            if (cur == 0)
                cur = 1;
            for (int k = 0; k < len; k++)
            begin
                case (mode)
                    6: price = $urandom;
                    7: price = int'($urandom_range(0, 40)) - 20;
                    8:
                    begin
                        case ($urandom_range(0, 5))
                            0: price = 32'sh7fff_ffff;
                            1: price = 32'sh8000_0000;
                            2: price = 32'sd0;
                            3: price = 32'sd1;
                            4: price = -32'sd1;
                            default: price = $urandom;
                        endcase
                    end
                    9:
                    begin
                        // small positive start, then crashes below zero mixed with small positive prices
                        if (k == 0)
                            price = $urandom_range(1, 1000);
                        else if ($urandom_range(0, 1) == 0)
                            price = -int'($urandom_range(0, 32'h7fff_ffff));
                        else
                            price = $urandom_range(0, 2000);
                    end
                    default:
                    begin
                        if (k != 0)
                        begin
                            d   = int'($urandom_range(0, 2000)) - 1100;
                            cur = cur + (cur / 1000) * d / 10 + d;
                            if (cur > 64'sh7fff_ffff)
                                cur = 64'sh7fff_ffff;
                            if (cur < -64'sh8000_0000)
                                cur = -64'sh8000_0000;
                        end
                        price = cur[31:0];
                    end
                endcase
                send_sample(price, k == len - 1);
            end
        end
    endtask

    // Result checker
    task automatic report_field(string name, longint expected_val, longint actual_val);
        if (expected_val != actual_val)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, expected_val, actual_val);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        drawdown_result_t r;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_drawdowns.size() == 0)
            begin
                $display("%0t: unexpected result transaction, actual dd %0d peak %0d",
                         $time, max_drawdown_bp, running_peak);
                fail_count++;
            end
            else
            begin
                r = pending_drawdowns.pop_front();
                report_field("max_drawdown_bp", r.dd_bp, max_drawdown_bp);
                report_field("drawdown_saturated", r.saturated, drawdown_saturated);
                report_field("running_peak", r.peak, running_peak);
                report_field("series_end", r.ends_series, series_end);
            end
        end
    end

    // Receiver stall: long hold-off on request, else random bursts
    always @(posedge clk)
    begin
        if (rx_hold_left != 0)
        begin
            out_stall <= 1'b1;
            rx_hold_left = rx_hold_left - 1;
        end
        else if (!rx_idle_en)
        begin
            out_stall <= 1'b0;
        end
        else if (rx_burst_left != 0)
        begin
            out_stall <= 1'b1;
            rx_burst_left = rx_burst_left - 1;
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            out_stall <= 1'b1;
            rx_burst_left = $urandom_range(1, 15) - 1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // Watchdog on cycles with no transaction on either channel
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else if (rst_n)
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        price_sample <= '0;
        last_sample  <= 1'b0;
        peak_q      = '0;
        worst_bp    = '0;
        sat_seen    = 1'b0;
        series_live = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_single_sample_series();
        test_nonpositive_peak();
        test_saturation();
        test_extreme_prices();
        test_output_backpressure();
        test_random_series();

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_drawdowns.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
